// ----- design/crp_pkg.sv -----
// ----------------------------------------------------------------------------
// crp_pkg: shared types and constants of the reset period calculator
// Schedule and action codes, the configuration bundle, the pipeline word
// and the reciprocal constants used for division by fixed numbers.
// ----------------------------------------------------------------------------
package crp_pkg;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_DAILY   = 2'd1,
    MODE_WEEKLY  = 2'd2,
    MODE_MONTHLY = 2'd3
  } sched_mode_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ADOPT = 2'd1,
    ACT_HOLD  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_BOUNDARY = 3'd1,
    REG_WEEKDAY  = 3'd2,
    REG_MDAY     = 3'd3,
    REG_WAKE_MIN = 3'd4,
    REG_WAKE_MAX = 3'd5
  } reg_index_t;

  typedef struct packed {
    sched_mode_t mode;
    logic [10:0] bmin;
    logic [2:0]  wday;
    logic [4:0]  mday;
    logic [16:0] wmin;
    logic [16:0] wmax;
  } cfg_t;

  // One word as it travels down the pipeline; each stage fills its fields.
  typedef struct packed {
    logic [36:0] s;         // biased, shifted seconds
    logic [30:0] stored;
    logic [29:0] t;         // s divided by 128
    logic [20:0] day2;      // day number plus two
    logic [16:0] sod;       // seconds into the shifted day
    logic [20:0] x7;        // day plus weekday offset plus seven
    logic [20:0] zz;        // day number from 0000-03-01
    logic [18:0] wk;
    logic [2:0]  ddays_w;
    logic [3:0]  era;
    logic [17:0] doe;
    logic [17:0] num;
    logic [8:0]  yoe;
    logic [8:0]  doy;
    logic [3:0]  mp;
    logic [4:0]  dday;
    logic [3:0]  mm;
    logic [12:0] year;
    logic [8:0]  ym;
    logic [16:0] period_m;
    logic [5:0]  ddays_m;
    logic [19:0] period;
    logic [22:0] wait_raw;
  } pipe_t;

  localparam int SPLIT_STAGES = 3;
  localparam int CIVIL_STAGES = 8;

  localparam logic [36:0] DAY_BIAS        = 37'd172800;
  localparam logic [20:0] EPOCH_DAY_SHIFT = 21'd719466;
  localparam logic [22:0] SEC_PER_DAY     = 23'd86400;

  // floor(x / d) = (x * M) >> K, exact for every x below 2**N when
  // K = N + clog2(d) and M = ceil(2**K / d).
  localparam int DAY_DIV_K  = 40;
  localparam logic [30:0] DAY_DIV_M =
    31'(((64'd1 << DAY_DIV_K) + 64'd674) / 64'd675);
  localparam int WEEK_DIV_K = 24;
  localparam logic [21:0] WEEK_DIV_M =
    22'(((64'd1 << WEEK_DIV_K) + 64'd6) / 64'd7);
  localparam int ERA_DIV_K  = 39;
  localparam logic [21:0] ERA_DIV_M =
    22'(((64'd1 << ERA_DIV_K) + 64'd146096) / 64'd146097);
  localparam int Q1460_K    = 29;
  localparam logic [18:0] Q1460_M =
    19'(((64'd1 << Q1460_K) + 64'd1459) / 64'd1460);
  localparam int Q365_K     = 27;
  localparam logic [18:0] Q365_M =
    19'(((64'd1 << Q365_K) + 64'd364) / 64'd365);
  localparam int Q153_K     = 19;
  localparam logic [11:0] Q153_M =
    12'(((64'd1 << Q153_K) + 64'd152) / 64'd153);
  localparam int Q5_K       = 14;
  localparam logic [11:0] Q5_M =
    12'(((64'd1 << Q5_K) + 64'd4) / 64'd5);

  // Offset that aligns weeks to the chosen weekday, (11 - wd) mod 7.
  function automatic logic [2:0] wk_offset(input logic [2:0] wd);
    logic [2:0] o;
    unique case (wd) inside
      3'd0, 3'd7: o = 3'd4;
      3'd1:       o = 3'd3;
      3'd2:       o = 3'd2;
      3'd3:       o = 3'd1;
      3'd4:       o = 3'd0;
      3'd5:       o = 3'd6;
      default:    o = 3'd5;
    endcase
    return o;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      4'd2:                    n = leap ? 5'd29 : 5'd28;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ----- design/crp_daysplit.sv -----
// ----------------------------------------------------------------------------
// crp_daysplit: day number and time of day
// Shifts the time back by the boundary minute and splits it into a day
// number and the seconds into that day, over three stages.
// ----------------------------------------------------------------------------
module crp_daysplit import crp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [35:0] local_seconds,
  input  logic [30:0] saved_period,
  output logic        out_valid,
  input  logic        out_ready,
  output pipe_t       out_data
);

  logic [SPLIT_STAGES-1:0] vld;
  logic [SPLIT_STAGES-1:0] rdy;
  logic [SPLIT_STAGES-1:0] prev;
  pipe_t st [SPLIT_STAGES];
  pipe_t nx [SPLIT_STAGES];

  always_comb begin
    rdy[SPLIT_STAGES-1] = !vld[SPLIT_STAGES-1] || out_ready;
    for (int k = SPLIT_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign prev = {vld[SPLIT_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < SPLIT_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= prev[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SPLIT_STAGES; k++) begin
      if (rdy[k] && prev[k]) begin
        st[k] <= nx[k];
      end
    end
  end

  always_comb begin
    logic [16:0] boff;
    logic [60:0] pday;
    logic [29:0] rem;
    // Stage one: biased shifted seconds, never negative.
    boff = 17'(cfg.bmin) * 17'd60;
    nx[0] = '0;
    nx[0].s = 37'(local_seconds) + DAY_BIAS - 37'(boff);
    nx[0].stored = saved_period;
    // Stage two: divide by 86400 as a shift by 7 and a division by 675.
    nx[1] = st[0];
    nx[1].t = st[0].s[36:7];
    pday = 61'(st[0].s[36:7]) * 61'(DAY_DIV_M);
    nx[1].day2 = pday[60:40];
    // Stage three: seconds into the day and the week and era operands.
    nx[2] = st[1];
    rem = st[1].t - 30'(st[1].day2) * 30'd675;
    nx[2].sod = {rem[9:0], st[1].s[6:0]};
    nx[2].x7 = st[1].day2 + 21'(wk_offset(cfg.wday)) + 21'd5;
    nx[2].zz = st[1].day2 + EPOCH_DAY_SHIFT;
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[SPLIT_STAGES-1];
  assign out_data  = st[SPLIT_STAGES-1];

endmodule

// ----- design/crp_civil.sv -----
// ----------------------------------------------------------------------------
// crp_civil: week number and civil date
// Computes the week number and days to the weekly boundary, and converts
// the day number into year, month and day to find the monthly period.
// ----------------------------------------------------------------------------
module crp_civil import crp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  pipe_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output pipe_t out_data
);

  logic [CIVIL_STAGES-1:0] vld;
  logic [CIVIL_STAGES-1:0] rdy;
  logic [CIVIL_STAGES-1:0] prev;
  pipe_t st [CIVIL_STAGES];
  pipe_t nx [CIVIL_STAGES];

  always_comb begin
    rdy[CIVIL_STAGES-1] = !vld[CIVIL_STAGES-1] || out_ready;
    for (int k = CIVIL_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign prev = {vld[CIVIL_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < CIVIL_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= prev[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CIVIL_STAGES; k++) begin
      if (rdy[k] && prev[k]) begin
        st[k] <= nx[k];
      end
    end
  end

  always_comb begin
    logic [42:0] pwk;
    logic [42:0] pera;
    logic [20:0] r7;
    logic [20:0] doe;
    logic [36:0] pa;
    logic [2:0]  b;
    logic        c;
    logic [36:0] py;
    logic [1:0]  cent;
    logic [17:0] yc;
    logic [10:0] v;
    logic [22:0] pm;
    logic [10:0] w;
    logic [22:0] pd;
    logic        jf;
    logic        leap;
    logic [4:0]  dom;
    logic [4:0]  dim;
    logic        early;

    // Week number and era.
    nx[0] = in_data;
    pwk = 43'(in_data.x7) * 43'(WEEK_DIV_M);
    nx[0].wk = pwk[42:24];
    pera = 43'(in_data.zz) * 43'(ERA_DIV_M);
    nx[0].era = pera[42:39];

    // Days to the weekly boundary and day of era.
    nx[1] = st[0];
    r7 = st[0].x7 - ((21'(st[0].wk) << 3) - 21'(st[0].wk));
    nx[1].ddays_w = 3'd7 - r7[2:0];
    doe = st[0].zz - 21'(st[0].era) * 21'd146097;
    nx[1].doe = doe[17:0];

    // Leap-day corrections of the day of era.
    nx[2] = st[1];
    pa = 37'(st[1].doe) * 37'(Q1460_M);
    if (st[1].doe >= 18'd146096) begin
      b = 3'd4;
    end else if (st[1].doe >= 18'd109572) begin
      b = 3'd3;
    end else if (st[1].doe >= 18'd73048) begin
      b = 3'd2;
    end else if (st[1].doe >= 18'd36524) begin
      b = 3'd1;
    end else begin
      b = 3'd0;
    end
    c = (st[1].doe == 18'd146096);
    nx[2].num = st[1].doe - 18'(pa[36:29]) + 18'(b) - 18'(c);

    // Year of era.
    nx[3] = st[2];
    py = 37'(st[2].num) * 37'(Q365_M);
    nx[3].yoe = 9'(py[36:27]);

    // Day of the year counted from March.
    nx[4] = st[3];
    if (st[3].yoe >= 9'd300) begin
      cent = 2'd3;
    end else if (st[3].yoe >= 9'd200) begin
      cent = 2'd2;
    end else if (st[3].yoe >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    yc = 18'(st[3].yoe) * 18'd365 + 18'(st[3].yoe[8:2]) - 18'(cent);
    nx[4].doy = 9'(st[3].doe - yc);

    // Month counted from March.
    nx[5] = st[4];
    v = (11'(st[4].doy) << 2) + 11'(st[4].doy) + 11'd2;
    pm = 23'(v) * 23'(Q153_M);
    nx[5].mp = pm[22:19];

    // Day of month, calendar month and year.
    nx[6] = st[5];
    w = (11'(st[5].mp) << 7) + (11'(st[5].mp) << 4) + (11'(st[5].mp) << 3)
        + 11'(st[5].mp) + 11'd2;
    pd = 23'(w) * 23'(Q5_M);
    nx[6].dday = 5'(st[5].doy - 9'(pd[22:14]) + 9'd1);
    nx[6].mm = (st[5].mp < 4'd10) ? st[5].mp + 4'd3 : st[5].mp - 4'd9;
    jf = (st[5].mp >= 4'd10);
    nx[6].ym = st[5].yoe + 9'(jf);
    nx[6].year = 13'(st[5].era) * 13'd400 + 13'(st[5].yoe) + 13'(jf);

    // Monthly period and days to the next monthly boundary.
    nx[7] = st[6];
    leap = (st[6].ym[1:0] == 2'd0) && (st[6].ym != 9'd100) && (st[6].ym != 9'd200)
           && (st[6].ym != 9'd300);
    if (cfg.mday == 5'd0) begin
      dom = 5'd1;
    end else if (cfg.mday > 5'd28) begin
      dom = 5'd28;
    end else begin
      dom = cfg.mday;
    end
    dim = month_days(st[6].mm, leap);
    early = (st[6].dday < dom);
    nx[7].period_m = (17'(st[6].year) << 3) + (17'(st[6].year) << 2)
                     + 17'(st[6].mm) - 17'(early);
    nx[7].ddays_m = early ? 6'(dom - st[6].dday) : 6'(dim - st[6].dday) + 6'(dom);
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[CIVIL_STAGES-1];
  assign out_data  = st[CIVIL_STAGES-1];

endmodule

// ----- design/crp_finish.sv -----
// ----------------------------------------------------------------------------
// crp_finish: period selection, wait clamp and action
// Picks the period of the configured schedule, forms the clamped wait and
// compares against the stored period in the output register.
// ----------------------------------------------------------------------------
module crp_finish import crp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  pipe_t       in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] active_period,
  output logic [16:0] wait_seconds,
  output logic [1:0]  action
);

  logic  v0;
  logic  v1;
  logic  r0;
  logic  r1;
  pipe_t p0;
  pipe_t p0_next;
  logic [30:0] period_next;
  logic [16:0] wait_next;
  action_t     action_next;

  assign r1 = !v1 || out_ready;
  assign r0 = !v0 || r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (r0) begin
        v0 <= in_valid;
      end
      if (r1) begin
        v1 <= v0;
      end
    end
  end

  always_comb begin
    logic [5:0] ddays;
    p0_next = in_data;
    unique case (cfg.mode)
      MODE_DAILY: begin
        p0_next.period = (in_data.day2 == 21'd0) ? 20'd0 : 20'(in_data.day2 - 21'd1);
        ddays = 6'd1;
      end
      MODE_WEEKLY: begin
        p0_next.period = 20'(in_data.wk);
        ddays = 6'(in_data.ddays_w);
      end
      MODE_MONTHLY: begin
        p0_next.period = 20'(in_data.period_m);
        ddays = in_data.ddays_m;
      end
      default: begin
        p0_next.period = 20'd0;
        ddays = 6'd1;
      end
    endcase
    p0_next.wait_raw = 23'(ddays) * SEC_PER_DAY - 23'(in_data.sod);
  end

  always_ff @(posedge clk) begin
    if (r0 && in_valid) begin
      p0 <= p0_next;
    end
  end

  always_comb begin
    logic [22:0] w1;
    logic [22:0] w2;
    w1 = (p0.wait_raw < 23'(cfg.wmin)) ? 23'(cfg.wmin) : p0.wait_raw;
    w2 = (w1 > 23'(cfg.wmax)) ? 23'(cfg.wmax) : w1;
    if (cfg.mode == MODE_OFF) begin
      period_next = 31'd0;
      wait_next   = 17'd0;
    end else begin
      period_next = 31'(p0.period);
      wait_next   = w2[16:0];
    end
    if (period_next == 31'd0) begin
      action_next = ACT_NONE;
    end else if (p0.stored == 31'd0) begin
      action_next = ACT_ADOPT;
    end else if (period_next == p0.stored) begin
      action_next = ACT_NONE;
    end else if (period_next < p0.stored) begin
      action_next = ACT_HOLD;
    end else begin
      action_next = ACT_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && v0) begin
      active_period <= period_next;
      wait_seconds  <= wait_next;
      action        <= action_next;
    end
  end

  assign in_ready  = r0;
  assign out_valid = v1;

endmodule

// ----- design/calendar_reset_period.sv -----
// ----------------------------------------------------------------------------
// calendar_reset_period: periodic reset schedule on civil dates
// Each input word carries a local time in seconds and a stored period; each
// output word gives the period holding that time, the clamped seconds to the
// next boundary and an action (none, adopt, hold, clear) for the stored one.
// Both channels use valid/ready. The block takes one word per clock while
// the pipeline is not backed up, and each word passes 13 register stages
// (3 for the day split, 8 for week and civil date, 2 for the wait and the
// action), each with its own valid bit. When the receiver stalls, words
// close up into empty stages, so input is refused only once every stage is
// full. The configuration port writes one register per enabled clock and is
// meant to be used only while no word is in flight. Reset empties the
// pipeline and loads the default schedule: daily at minute 180, wake clamp
// 60 to 86400 seconds.
// ----------------------------------------------------------------------------
module calendar_reset_period import crp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [35:0] local_seconds,
  input  logic [30:0] saved_period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] active_period,
  output logic [16:0] wait_seconds,
  output logic [1:0]  action
);

  cfg_t  cfg;
  logic  split_valid;
  logic  split_ready;
  pipe_t split_data;
  logic  civil_valid;
  logic  civil_ready;
  pipe_t civil_data;

  // Configuration registers; indexes with no register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_DAILY;
      cfg.bmin <= 11'd180;
      cfg.wday <= 3'd1;
      cfg.mday <= 5'd1;
      cfg.wmin <= 17'd60;
      cfg.wmax <= 17'd86400;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:     cfg.mode <= sched_mode_t'(cfg_data[1:0]);
        REG_BOUNDARY: cfg.bmin <= cfg_data[10:0];
        REG_WEEKDAY:  cfg.wday <= cfg_data[2:0];
        REG_MDAY:     cfg.mday <= cfg_data[4:0];
        REG_WAKE_MIN: cfg.wmin <= cfg_data;
        REG_WAKE_MAX: cfg.wmax <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Day number and seconds into the day.
  crp_daysplit u_split (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .local_seconds (local_seconds),
    .saved_period  (saved_period),
    .out_valid     (split_valid),
    .out_ready     (split_ready),
    .out_data      (split_data)
  );

  // Week number and civil date.
  crp_civil u_civil (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_data   (split_data),
    .out_valid (civil_valid),
    .out_ready (civil_ready),
    .out_data  (civil_data)
  );

  // Period choice, wait clamp and action, ending in the output register.
  crp_finish u_finish (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (civil_valid),
    .in_ready      (civil_ready),
    .in_data       (civil_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .active_period (active_period),
    .wait_seconds  (wait_seconds),
    .action        (action)
  );

`ifndef SYNTHESIS
  // Input is refused only when the whole pipeline is backed up.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input refused while the output is not stalled");

  // An idle schedule gives an all-zero word.
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cfg.mode == MODE_OFF) |->
      (active_period == 31'd0 && wait_seconds == 17'd0 && action == ACT_NONE))
    else $error("non-zero result with the schedule off");

  // The wait never exceeds the upper clamp.
  a_wait_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wait_seconds <= cfg.wmax))
    else $error("wait above the upper clamp");

  // A zero period never asks for an action.
  a_zero_none: assert property (@(posedge clk) disable iff (rst)
    (out_valid && active_period == 31'd0) |-> (action == ACT_NONE))
    else $error("action given for a zero period");
`endif

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the civil-date reset period calculator
// A directed set of times around the rollover and the field extremes runs
// first. Random phases follow, each under a fresh schedule, with bursty input
// and a receiver that stalls. Every result is checked field by field against
// a predictor built into the scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
  import crp_pkg::*;

  typedef struct {
    logic [30:0] period;
    logic [16:0] wait_s;
    action_t     act;
  } period_result_t;

  localparam longint DAY_SECS = 86400;
  localparam longint MAX_SECS = 64'h0F_FFFF_FFFF;
  localparam int     DRAIN_CYCLES = 16;

  // Scoreboard: a private copy of the schedule, the predictor and the queue
  // of results still owed by the block.
  class reset_period_board;
    cfg_t           sched;
    period_result_t owed_q[$];
    int unsigned    errors;

    function new();
      sched.mode = MODE_DAILY;
      sched.bmin = 11'd180;
      sched.wday = 3'd1;
      sched.mday = 5'd1;
      sched.wmin = 17'd60;
      sched.wmax = 17'd86400;
      errors = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [16:0] data);
      case (idx)
        REG_MODE:     sched.mode = sched_mode_t'(data[1:0]);
        REG_BOUNDARY: sched.bmin = data[10:0];
        REG_WEEKDAY:  sched.wday = data[2:0];
        REG_MDAY:     sched.mday = data[4:0];
        REG_WAKE_MIN: sched.wmin = data;
        REG_WAKE_MAX: sched.wmax = data;
        default: ;
      endcase
    endfunction

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b != 0) && ((a < 0) != (b < 0)))
        q--;
      return q;
    endfunction

    // Day number since 1970-01-01 to a proleptic Gregorian date.
    function void civil_from_day(longint z, output longint y, output longint m,
                                 output longint d);
      longint zz, era, doe, yoe, doy, mp;
      zz  = z + 719468;
      era = floor_div(zz, 146097);
      doe = zz - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      m   = (mp < 10) ? mp + 3 : mp - 9;
      d   = doy - (153 * mp + 2) / 5 + 1;
      y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    endfunction

    function longint day_from_civil(longint y, longint m, longint d);
      longint yy, era, yoe, doy, doe;
      yy  = y - ((m <= 2) ? 1 : 0);
      era = floor_div(yy, 400);
      yoe = yy - era * 400;
      doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
    endfunction

    function period_result_t predict(logic [35:0] secs, logic [30:0] stored);
      period_result_t r;
      longint t, boff, day, bday, period, wait_v, off, wk, dom, y, m, d, months;
      t = longint'(secs);
      period = 0;
      wait_v = 0;
      if (sched.mode != MODE_OFF) begin
        boff = longint'(sched.bmin) * 60;
        day  = floor_div(t - boff, DAY_SECS);
        if (sched.mode == MODE_DAILY) begin
          period = day + 1;
          bday   = day + 1;
        end else if (sched.mode == MODE_WEEKLY) begin
          off    = (11 - longint'(sched.wday)) % 7;
          wk     = floor_div(day + off, 7) + 1;
          period = wk;
          bday   = wk * 7 - off;
        end else begin
          dom = longint'(sched.mday);
          if (dom < 1) dom = 1;
          if (dom > 28) dom = 28;
          civil_from_day(day, y, m, d);
          months = y * 12 + (m - 1);
          if (d < dom)
            months -= 1;
          period = months + 1;
          if (d >= dom) begin
            m++;
            if (m > 12) begin
              m = 1;
              y++;
            end
          end
          bday = day_from_civil(y, m, dom);
        end
        if (period < 0)
          period = 0;
        wait_v = bday * DAY_SECS + boff - t;
        if (wait_v < longint'(sched.wmin)) wait_v = longint'(sched.wmin);
        if (wait_v > longint'(sched.wmax)) wait_v = longint'(sched.wmax);
      end
      if (period == 0)                         r.act = ACT_NONE;
      else if (stored == 0)                    r.act = ACT_ADOPT;
      else if (period == longint'(stored))     r.act = ACT_NONE;
      else if (period < longint'(stored))      r.act = ACT_HOLD;
      else                                     r.act = ACT_CLEAR;
      r.period = period[30:0];
      r.wait_s = wait_v[16:0];
      return r;
    endfunction

    function void note_word(logic [35:0] secs, logic [30:0] stored);
      owed_q.push_back(predict(secs, stored));
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_word(logic [30:0] period, logic [16:0] wait_s, logic [1:0] act);
      period_result_t e;
      if (owed_q.size() == 0) begin
        report("result with nothing owed");
        return;
      end
      e = owed_q.pop_front();
      if (period !== e.period)
        report($sformatf("active_period %0d, predicted %0d", period, e.period));
      if (wait_s !== e.wait_s)
        report($sformatf("wait_seconds %0d, predicted %0d", wait_s, e.wait_s));
      if (act !== e.act)
        report($sformatf("action %0d, predicted %s", act, e.act.name()));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [35:0] local_seconds;
  logic [30:0] saved_period;
  logic        out_valid;
  logic        out_ready;
  logic [30:0] active_period;
  logic [16:0] wait_seconds;
  logic [1:0]  action;

  reset_period_board board;
  int unsigned burst_left;
  bit          no_gaps;
  int unsigned stall_style = 0;
  int unsigned stall_count = 0;

  calendar_reset_period dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .local_seconds (local_seconds),
    .saved_period  (saved_period),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .active_period (active_period),
    .wait_seconds  (wait_seconds),
    .action        (action)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Both handshakes are sampled at the rising edge, before the block's own
  // registers move, so the order of processes within the step is irrelevant.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        board.note_word(local_seconds, saved_period);
      if (out_valid && out_ready)
        board.check_word(active_period, wait_seconds, action);
    end
  end

  // The receiver periodically draws a new stall habit at random:
  // always ready, coin toss, one cycle in four, or long stalls.
  always @(negedge clk) begin
    stall_count <= stall_count + 1;
    if (stall_count % 200 == 0)
      stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (stall_count % 4 == 0);
      default: out_ready <= (stall_count % 40 < 5);
    endcase
  end

  // Writes one register; the scoreboard copy follows at the same moment.
  task write_reg(reg_index_t idx, logic [16:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task write_schedule(logic [1:0] mode, logic [10:0] bmin, logic [2:0] wday,
                      logic [4:0] mday, logic [16:0] wmin, logic [16:0] wmax);
    write_reg(REG_MODE, {15'd0, mode});
    write_reg(REG_BOUNDARY, {6'd0, bmin});
    write_reg(REG_WEEKDAY, {14'd0, wday});
    write_reg(REG_MDAY, {12'd0, mday});
    write_reg(REG_WAKE_MIN, wmin);
    write_reg(REG_WAKE_MAX, wmax);
  endtask

  // Holds a word on the inputs until it is taken; returns at a falling edge,
  // where the caller either presents the next word or lowers valid.
  task send_word(logic [35:0] secs, logic [30:0] stored);
    in_valid      = 1'b1;
    local_seconds = secs;
    saved_period  = stored;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    @(negedge clk);
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!no_gaps) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
    end
  endtask

  // The block is idle once nothing is owed and the pipe has had time to empty.
  task drain;
    in_valid = 1'b0;
    while (board.owed_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Stored values around the predicted period exercise hold, clear and none.
  function logic [30:0] pick_stored(logic [35:0] secs);
    period_result_t p;
    p = board.predict(secs, 31'd1);
    case ($urandom_range(0, 5))
      0:       return 31'd0;
      1:       return p.period;
      2:       return p.period + 31'd1;
      3:       return p.period - 31'd1;
      4:       return 31'h7FFF_FFFF;
      default: return 31'($urandom());
    endcase
  endfunction

  // A third of the times land within a few seconds of a rollover, which is where the
  // floor division and the clamps earn their keep.
  function logic [35:0] pick_seconds();
    longint t, y, m;
    case ($urandom_range(0, 5))
      0: t = {$urandom(), $urandom()} & MAX_SECS;
      1: t = $urandom_range(0, 3 * 86400);
      2: t = longint'($urandom_range(0, 795000)) * DAY_SECS
             + longint'(board.sched.bmin) * 60 + $urandom_range(0, 6) - 3;
      3: begin
        y = $urandom_range(1970, 4146);
        m = $urandom_range(1, 12);
        t = board.day_from_civil(y, m, $urandom_range(1, 28)) * DAY_SECS
            + longint'(board.sched.bmin) * 60 + $urandom_range(0, 6) - 3;
      end
      4: t = MAX_SECS - $urandom_range(0, 200000);
      default: t = longint'($urandom_range(0, 795000)) * DAY_SECS
                   + $urandom_range(0, 86399);
    endcase
    if (t < 0) t = 0;
    if (t > MAX_SECS) t = MAX_SECS;
    return t[35:0];
  endfunction

  task run_random(int unsigned count);
    logic [35:0] secs;
    repeat (count) begin
      secs = pick_seconds();
      send_word(secs, pick_stored(secs));
    end
  endtask

  initial begin
    longint edge_secs [8];
    board         = new();
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_MODE;
    cfg_data      = '0;
    in_valid      = 1'b0;
    local_seconds = '0;
    saved_period  = '0;
    out_ready     = 1'b0;
    burst_left    = 1;
    no_gaps       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset schedule: early times before the first
    // rollover, both sides of the boundary second, and the top of the range.
    edge_secs = '{0, 10799, 10800, 10801, 86399, 97199, 97200, MAX_SECS};
    foreach (edge_secs[i])
      send_word(edge_secs[i][35:0], i[0] ? 31'h7FFF_FFFF : 31'd0);
    foreach (edge_secs[i])
      send_word(edge_secs[i][35:0], pick_stored(edge_secs[i][35:0]));
    send_word(36'd200000, 31'd3);
    send_word(36'd200000, 31'd2);
    send_word(36'd200000, 31'd1);
    drain();

    // Fixed schedules covering every mode and the register extremes: the
    // schedule switched off, the first and last legal minutes and a minute
    // beyond the day, every weekday including the alias of Sunday, days of
    // month below, at and above the legal range, and a wake clamp whose
    // minimum sits above its maximum.
    write_schedule(MODE_OFF, 11'd0, 3'd0, 5'd1, 17'd0, 17'd0);
    run_random(40);
    drain();
    write_schedule(MODE_DAILY, 11'd0, 3'd0, 5'd1, 17'd0, 17'h1FFFF);
    run_random(80);
    drain();
    write_schedule(MODE_DAILY, 11'd2047, 3'd7, 5'd31, 17'd1, 17'd86400);
    run_random(80);
    drain();
    for (int wd = 0; wd < 8; wd++) begin
      write_schedule(MODE_WEEKLY, wd[10:0] * 11'd205, wd[2:0], 5'd1, 17'd60,
                     17'd86400);
      run_random(40);
      drain();
    end
    write_schedule(MODE_MONTHLY, 11'd1439, 3'd1, 5'd0, 17'd60, 17'd86400);
    run_random(80);
    drain();
    write_schedule(MODE_MONTHLY, 11'd180, 3'd1, 5'd28, 17'd1, 17'd1);
    run_random(80);
    drain();
    write_schedule(MODE_MONTHLY, 11'd0, 3'd1, 5'd31, 17'h1FFFF, 17'd100);
    run_random(80);
    drain();

    // Random schedules over the full width of each register; some phases
    // push words back to back with no gaps at all.
    repeat (6) begin
      write_schedule(2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)),
                     3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                     17'($urandom_range(0, 131071)),
                     17'($urandom_range(0, 131071)));
      no_gaps = ($urandom_range(0, 2) == 0);
      run_random(80);
      drain();
    end
    no_gaps = 1'b0;

    if (board.errors == 0)
      $display("calendar_reset_period verification clean");
    else
      $display("calendar_reset_period verification failed");
    $finish;
  end

  // Far beyond the slowest correct run of this stimulus.
  initial begin
    #20000000;
    $display("calendar_reset_period verification failed");
    $finish;
  end

endmodule
